FILE: hdl/rlf_pkg.sv
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared widths, defaults and the item record that travels along the chain of
// table cells in the repeat limit filter.
// ----------------------------------------------------------------------------
package rlf_pkg;

  localparam int VALUE_W            = 32;
  localparam int CNT_W              = 2;
  localparam int TABLE_SIZE_DEFAULT = 64;
  localparam int KEEP_LIMIT_DEFAULT = 2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  // An item on its way through the chain. The done flag is set by the cell
  // that found or stored the value; keep is meaningful once done is set.
  typedef struct packed {
    value_t value;
    logic   last;
    logic   done;
    logic   keep;
  } item_t;

endpackage

FILE: hdl/rlf_if.sv
// ----------------------------------------------------------------------------
// rlf_in_if / rlf_out_if
// Valid/ready channels carrying input items and result items of the repeat
// limit filter.
// ----------------------------------------------------------------------------
interface rlf_in_if;
  logic            valid;
  logic            ready;
  rlf_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface rlf_out_if;
  logic            valid;
  logic            ready;
  rlf_pkg::value_t value_out;
  logic            keep;
  logic            last_out;
  logic            overflow;

  modport source (output valid, output value_out, output keep, output last_out,
                  output overflow, input ready);
  modport sink   (input valid, input value_out, input keep, input last_out,
                  input overflow, output ready);
endinterface

FILE: hdl/rlf_cell.sv
// ----------------------------------------------------------------------------
// rlf_cell
// One entry of the value table. An item passing through compares against the
// stored value, updates the count or claims a free entry, and moves on to the
// next cell on advance. An item marked last empties the entry behind it.
// ----------------------------------------------------------------------------
module rlf_cell #(
  parameter int KEEP_LIMIT = rlf_pkg::KEEP_LIMIT_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           in_valid,
  input  rlf_pkg::item_t in_item,
  output logic           out_valid,
  output rlf_pkg::item_t out_item
);

  rlf_pkg::value_t ent_value;
  rlf_pkg::count_t ent_count;
  logic            ent_valid;

  rlf_pkg::value_t ent_value_next;
  rlf_pkg::count_t ent_count_next;
  logic            ent_valid_next;
  rlf_pkg::item_t  item_next;
  logic            match;

  assign match = ent_valid && (ent_value == in_item.value);

  always_comb begin
    ent_value_next = ent_value;
    ent_count_next = ent_count;
    ent_valid_next = ent_valid;
    item_next      = in_item;
    if (!in_item.done) begin
      if (match) begin
        item_next.done = 1'b1;
        if (ent_count < rlf_pkg::CNT_W'(KEEP_LIMIT)) begin
          ent_count_next = ent_count + rlf_pkg::CNT_W'(1);
          item_next.keep = 1'b1;
        end else begin
          item_next.keep = 1'b0;
        end
      end else if (!ent_valid) begin
        ent_value_next = in_item.value;
        ent_count_next = rlf_pkg::CNT_W'(1);
        ent_valid_next = 1'b1;
        item_next.done = 1'b1;
        item_next.keep = 1'b1;
      end
    end
    if (in_item.last) begin
      ent_count_next = '0;
      ent_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      ent_count <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
      if (in_valid) begin
        ent_valid <= ent_valid_next;
        ent_count <= ent_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
      if (in_valid) begin
        ent_value <= ent_value_next;
      end
    end
  end

endmodule

FILE: hdl/repeat_limit_filter.sv
// ----------------------------------------------------------------------------
// repeat_limit_filter
// Passes signed values through, flagging each value's first KEEP_LIMIT
// occurrences in a list as kept, later repeats as dropped, overflow as kept.
// ----------------------------------------------------------------------------
// Each item walks a chain of TABLE_SIZE cells, one table entry per cell and
// one cell per cycle while the chain advances. The first cell registers the
// item at the edge that accepts it, each later cell registers it in turn, and
// the last cell's register drives the output. A new item may enter every
// cycle; the whole chain holds while a result waits at the output, so the
// sustained rate is one item per cycle when the sink takes every result.
// The item marked last empties the table as it passes, and items of the
// next list may follow directly behind it.
// ----------------------------------------------------------------------------
module repeat_limit_filter #(
  parameter int TABLE_SIZE = rlf_pkg::TABLE_SIZE_DEFAULT,
  parameter int KEEP_LIMIT = rlf_pkg::KEEP_LIMIT_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  rlf_in_if.sink   din,
  rlf_out_if.source dout
);

  logic                  advance;
  logic [TABLE_SIZE-1:0] stage_valid;
  rlf_pkg::item_t        stage_item [TABLE_SIZE];
  rlf_pkg::item_t        entry_item;
  rlf_pkg::item_t        tail;

  assign advance = !stage_valid[TABLE_SIZE-1] || dout.ready;
  assign din.ready = advance;

  always_comb begin
    entry_item.value = din.value;
    entry_item.last  = din.last;
    entry_item.done  = 1'b0;
    entry_item.keep  = 1'b0;
  end

  for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_head
      rlf_cell #(.KEEP_LIMIT(KEEP_LIMIT)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .in_valid  (din.valid),
        .in_item   (entry_item),
        .out_valid (stage_valid[i]),
        .out_item  (stage_item[i])
      );
    end else begin : g_body
      rlf_cell #(.KEEP_LIMIT(KEEP_LIMIT)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .in_valid  (stage_valid[i-1]),
        .in_item   (stage_item[i-1]),
        .out_valid (stage_valid[i]),
        .out_item  (stage_item[i])
      );
    end
  end

  assign tail = stage_item[TABLE_SIZE-1];

  assign dout.valid     = stage_valid[TABLE_SIZE-1];
  assign dout.value_out = tail.value;
  assign dout.last_out  = tail.last;
  assign dout.overflow  = !tail.done;
  assign dout.keep      = tail.done ? tail.keep : 1'b1;

  a_overflow_kept: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.overflow |-> dout.keep)
    else $error("overflowed item not kept");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> stage_valid[0])
    else $error("accepted item missing from first cell");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(stage_valid))
    else $error("chain moved while stalled");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !dout.valid |-> din.ready)
    else $error("input refused while output empty");

endmodule

FILE: test/repeat_limit_filter_tb.sv
// ----------------------------------------------------------------------------
// repeat_limit_filter_tb
// Self-checking bench for the repeat limit filter. A short table of directed
// items comes first, followed by random lists of several shapes: many repeats
// from small pools, lists that fill the table and overflow it, plain noise,
// and lists whose last mark falls early or is missing. The sender idles in
// bursts and the receiver stalls on a pattern of its own. Every result is
// compared field by field with a software model of the value table.
// ----------------------------------------------------------------------------
module repeat_limit_filter_tb;

  localparam int TABLE_SIZE   = rlf_pkg::TABLE_SIZE_DEFAULT;
  localparam int KEEP_LIMIT   = rlf_pkg::KEEP_LIMIT_DEFAULT;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = TABLE_SIZE + 40;
  localparam int REPORT_MAX   = 10;
  localparam int DIR_ROWS     = 23;

  localparam rlf_pkg::value_t V_MIN  = 32'h8000_0000;
  localparam rlf_pkg::value_t V_MAX  = 32'h7fff_ffff;
  localparam rlf_pkg::value_t V_ONES = 32'hffff_ffff;
  localparam rlf_pkg::value_t V_ALT5 = 32'h5555_5555;
  localparam rlf_pkg::value_t V_ALTA = 32'haaaa_aaaa;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_STARVE,
    RX_PERIODIC
  } rx_mode_t;

  typedef struct packed {
    rlf_pkg::value_t value;
    logic            keep;
    logic            last;
    logic            overflow;
  } result_t;

  typedef struct packed {
    rlf_pkg::value_t value;
    logic            last;
    logic            typed;
    logic            keep;
    logic            overflow;
  } dir_row_t;

  // Rows with typed set carry their own expected keep and overflow.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{32'sd0,  1'b0, 1'b1, 1'b1, 1'b0},
    '{32'sd0,  1'b0, 1'b1, 1'b1, 1'b0},
    '{32'sd0,  1'b0, 1'b1, 1'b0, 1'b0},
    '{32'sd0,  1'b0, 1'b1, 1'b0, 1'b0},
    '{V_MIN,   1'b0, 1'b1, 1'b1, 1'b0},
    '{V_MAX,   1'b0, 1'b1, 1'b1, 1'b0},
    '{V_MIN,   1'b0, 1'b1, 1'b1, 1'b0},
    '{V_MIN,   1'b0, 1'b1, 1'b0, 1'b0},
    '{V_MAX,   1'b0, 1'b1, 1'b1, 1'b0},
    '{V_ONES,  1'b0, 1'b1, 1'b1, 1'b0},
    '{32'sd1,  1'b0, 1'b1, 1'b1, 1'b0},
    '{V_ONES,  1'b0, 1'b1, 1'b1, 1'b0},
    '{V_ONES,  1'b1, 1'b1, 1'b0, 1'b0},
    '{V_ONES,  1'b0, 1'b1, 1'b1, 1'b0},
    '{32'sd0,  1'b0, 1'b1, 1'b1, 1'b0},
    '{V_MAX,   1'b1, 1'b1, 1'b1, 1'b0},
    '{V_MAX,   1'b1, 1'b1, 1'b1, 1'b0},
    '{V_ALT5,  1'b0, 1'b1, 1'b1, 1'b0},
    '{V_ALTA,  1'b0, 1'b1, 1'b1, 1'b0},
    '{V_ALT5,  1'b1, 1'b1, 1'b1, 1'b0},
    '{V_ALTA,  1'b0, 1'b1, 1'b1, 1'b0},
    '{V_ALTA,  1'b0, 1'b0, 1'b0, 1'b0},
    '{V_ALTA,  1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  rlf_in_if  din ();
  rlf_out_if dout ();

  repeat_limit_filter #(
    .TABLE_SIZE (TABLE_SIZE),
    .KEEP_LIMIT (KEEP_LIMIT)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rlf_pkg::value_t seen_val  [TABLE_SIZE];
  rlf_pkg::count_t seen_cnt  [TABLE_SIZE];
  logic            seen_used [TABLE_SIZE];
  result_t         expected_results [$];
  rlf_pkg::value_t item_values [$];
  logic            item_lasts  [$];
  int              accepted_items = 0;
  int              fail_count     = 0;
  int              idle_cycles    = 0;
  rx_mode_t        rx_mode        = RX_OPEN;
  int              rx_left        = 0;
  int              rx_tick        = 0;

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      seen_val[i]  = '0;
      seen_cnt[i]  = '0;
      seen_used[i] = 1'b0;
    end
  end

  function automatic result_t filter_step(rlf_pkg::value_t v, logic lst);
    result_t r;
    int hit;
    int free_slot;
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (seen_used[i]) begin
        if (hit < 0 && seen_val[i] == v) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    r.value    = v;
    r.last     = lst;
    r.keep     = 1'b1;
    r.overflow = 1'b0;
    if (hit >= 0) begin
      if (seen_cnt[hit] < KEEP_LIMIT) seen_cnt[hit] = seen_cnt[hit] + 1'b1;
      else r.keep = 1'b0;
    end else if (free_slot >= 0) begin
      seen_val[free_slot]  = v;
      seen_cnt[free_slot]  = rlf_pkg::count_t'(1);
      seen_used[free_slot] = 1'b1;
    end else begin
      r.overflow = 1'b1;
    end
    if (lst) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        seen_cnt[i]  = '0;
        seen_used[i] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic rlf_pkg::value_t pick_value();
    case ($urandom_range(0, 7))
      0: return V_MIN;
      1: return V_MAX;
      2: return V_ONES;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin : accept_mon
    result_t r;
    if (!rst && din.valid && din.ready) begin
      r = filter_step(din.value, din.last);
      if (accepted_items < DIR_ROWS && dir_rows[accepted_items].typed) begin
        r.keep     = dir_rows[accepted_items].keep;
        r.overflow = dir_rows[accepted_items].overflow;
      end
      expected_results.push_back(r);
      accepted_items++;
    end
  end

  always @(posedge clk) begin : result_mon
    result_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("Unexpected item: value %h keep %b last %b overflow %b",
                   dout.value_out, dout.keep, dout.last_out, dout.overflow);
      end else begin
        want = expected_results.pop_front();
        if (dout.value_out !== want.value || dout.keep !== want.keep ||
            dout.last_out !== want.last || dout.overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("Mismatch: expected value %h keep %b last %b overflow %b, got %h %b %b %b",
                     want.value, want.keep, want.last, want.overflow,
                     dout.value_out, dout.keep, dout.last_out, dout.overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 120);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:     dout.ready <= 1'b1;
      RX_COIN:     dout.ready <= ($urandom_range(0, 1) == 1);
      RX_STARVE:   dout.ready <= ($urandom_range(0, 5) == 0);
      RX_PERIODIC: dout.ready <= (rx_tick % 3 != 0);
      default:     dout.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((din.valid && din.ready) || (dout.valid && dout.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("repeat_limit_filter_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rlf_pkg::value_t pool [8];
    rlf_pkg::value_t fill_vals [$];
    int              pool_n;
    int              len;
    int              shape;
    int              burst_left;
    int              gap;
    rlf_pkg::value_t base;
    rlf_pkg::value_t stride;

    din.valid  <= 1'b0;
    din.value  <= '0;
    din.last   <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      item_values.push_back(dir_rows[i].value);
      item_lasts.push_back(dir_rows[i].last);
    end

    while (item_values.size() < DIR_ROWS + RANDOM_ITEMS) begin
      shape = $urandom_range(0, 9);
      if (shape <= 3 || shape == 8) begin
        pool_n = $urandom_range(1, 8);
        for (int i = 0; i < pool_n; i++) pool[i] = pick_value();
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) begin
          item_values.push_back(pool[$urandom_range(0, pool_n - 1)]);
          if (shape == 8) item_lasts.push_back($urandom_range(0, 7) == 0);
          else item_lasts.push_back(i == len - 1);
        end
      end else if (shape <= 5) begin
        fill_vals.delete();
        base   = $urandom;
        stride = $urandom | 32'h1;
        len    = $urandom_range(TABLE_SIZE - 2, TABLE_SIZE + 6);
        for (int i = 0; i < len; i++) begin
          fill_vals.push_back(base + i * stride);
          item_values.push_back(base + i * stride);
          item_lasts.push_back(1'b0);
        end
        len = $urandom_range(4, 24);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0) item_values.push_back(pick_value());
          else item_values.push_back(fill_vals[$urandom_range(0, fill_vals.size() - 1)]);
          item_lasts.push_back(i == len - 1 && $urandom_range(0, 9) != 0);
        end
      end else if (shape <= 7) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) begin
          item_values.push_back($urandom);
          item_lasts.push_back(i == len - 1 && $urandom_range(0, 9) != 0);
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          item_values.push_back(pick_value());
          item_lasts.push_back(1'b1);
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst_left = 0;
    for (int idx = 0; idx < item_values.size(); idx++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 80);
          gap        = 0;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap        = $urandom_range(0, 12);
        end
        if (gap > 0) begin
          din.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      din.valid <= 1'b1;
      din.value <= item_values[idx];
      din.last  <= item_lasts[idx];
      do @(posedge clk); while (!din.ready);
      burst_left--;
    end
    din.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("repeat_limit_filter_tb: clean");
    end else begin
      $display("repeat_limit_filter_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rlf_pkg.sv
hdl/rlf_if.sv
hdl/rlf_cell.sv
hdl/repeat_limit_filter.sv
test/repeat_limit_filter_tb.sv
